// File: rtl/segment_grid_cell_walker_defines.svh
// Assertion macros for the RTL of the segment grid cell walker, used by sgcw_walker.
// A module that uses them must have ports named clk and arst_n.
`ifndef SEGMENT_GRID_CELL_WALKER_DEFINES_SVH
`define SEGMENT_GRID_CELL_WALKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SGCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SGCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SGCW_ASSERT_IMPLY(lbl, ante, cons, msg)

`define SGCW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/sgcw_pkg.sv
`timescale 1ns / 1ps

package sgcw_pkg;

	localparam int GRID_BITS      = 5;
	localparam int FRAC_BITS      = 8;
	localparam int COORD_BITS     = GRID_BITS + FRAC_BITS;
	localparam int DIFF_BITS      = 2 * COORD_BITS + 3;
	localparam int FIELD_BITS     = 13;
	localparam int CELL_BITS      = 5;
	localparam int IN_TDATA_BITS  = ((4 * FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((2 * CELL_BITS + 7) / 8) * 8;
	localparam int QUEUE_DEPTH    = 2;

	typedef logic [GRID_BITS-1:0]         cell_t;
	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic [FIELD_BITS-1:0]        field_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;

	// One classified segment, ready for the walker.
	typedef struct packed {
		cell_t col;
		cell_t row;
		cell_t end_col;
		cell_t end_row;
		logic  rising;
		diff_t diff;
		diff_t step_x;
		diff_t step_y;
	} job_t;

endpackage

// File: rtl/sgcw_front.sv
`timescale 1ns / 1ps

module sgcw_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sgcw_pkg::field_t start_x,
	input  sgcw_pkg::field_t start_y,
	input  sgcw_pkg::field_t finish_x,
	input  sgcw_pkg::field_t finish_y,
	output logic            job_valid,
	input  logic            job_ready,
	output sgcw_pkg::job_t  job
);
	import sgcw_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;

	front_state_t state_q;
	coord_t       ax_q, ay_q, bx_q, by_q;
	diff_t        lhs_q, rhs_q;
	logic [COORD_BITS-1:0]      dx_q;
	logic signed [COORD_BITS:0] dy_q;
	logic         rising_q;

	coord_t sx, sy, fx, fy;
	logic   swap;
	logic [COORD_BITS-1:0]        dx;
	logic signed [COORD_BITS:0]   dy;
	logic                         rising;
	logic [COORD_BITS:0]          edge_y, edge_x;
	logic signed [COORD_BITS+1:0] fa, fb;
	diff_t                        lhs_prod, rhs_prod;

	assign sx   = start_x[COORD_BITS-1:0];
	assign sy   = start_y[COORD_BITS-1:0];
	assign fx   = finish_x[COORD_BITS-1:0];
	assign fy   = finish_y[COORD_BITS-1:0];
	assign swap = fx < sx;

	assign dx     = bx_q - ax_q;
	assign dy     = $signed({1'b0, by_q}) - $signed({1'b0, ay_q});
	assign rising = ay_q <= by_q;

	// A rising segment tests the edge above its row, a falling one the edge below.
	assign edge_y = {({1'b0, ay_q[COORD_BITS-1:FRAC_BITS]} + {{GRID_BITS{1'b0}}, rising}),
		{FRAC_BITS{1'b0}}};
	assign edge_x = {({1'b0, ax_q[COORD_BITS-1:FRAC_BITS]} + {{GRID_BITS{1'b0}}, 1'b1}),
		{FRAC_BITS{1'b0}}};
	assign fa = $signed({1'b0, edge_y}) - $signed({2'b00, ay_q});
	assign fb = $signed({1'b0, edge_x}) - $signed({2'b00, ax_q});
	assign lhs_prod = fa * $signed({1'b0, dx});
	assign rhs_prod = fb * dy;

	assign in_ready  = state_q == F_IDLE;
	assign job_valid = state_q == F_PUSH;

	always_comb begin
		job.col     = ax_q[COORD_BITS-1:FRAC_BITS];
		job.row     = ay_q[COORD_BITS-1:FRAC_BITS];
		job.end_col = bx_q[COORD_BITS-1:FRAC_BITS];
		job.end_row = by_q[COORD_BITS-1:FRAC_BITS];
		job.rising  = rising_q;
		job.diff    = lhs_q - rhs_q;
		job.step_x  = DIFF_BITS'($signed({1'b0, dx_q, {FRAC_BITS{1'b0}}}));
		job.step_y  = DIFF_BITS'($signed({dy_q, {FRAC_BITS{1'b0}}}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			ax_q <= swap ? fx : sx;
			ay_q <= swap ? fy : sy;
			bx_q <= swap ? sx : fx;
			by_q <= swap ? sy : fy;
		end
		if (state_q == F_MUL) begin
			lhs_q    <= lhs_prod;
			rhs_q    <= rhs_prod;
			dx_q     <= dx;
			dy_q     <= dy;
			rising_q <= rising;
		end
	end

endmodule

// File: rtl/sgcw_queue.sv
`timescale 1ns / 1ps

module sgcw_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  sgcw_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output sgcw_pkg::job_t pop_job
);
	import sgcw_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	job_t                entry_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_q, rd_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push, do_pop;

	assign push_ready = count_q != CNT_BITS'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = entry_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_job;
		end
	end

endmodule

// File: rtl/sgcw_walker.sv
`timescale 1ns / 1ps

module sgcw_walker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  sgcw_pkg::job_t  job,
	output logic            out_valid,
	input  logic            out_ready,
	output sgcw_pkg::cell_t out_cell_x,
	output sgcw_pkg::cell_t out_cell_y,
	output logic            out_last
);
	import sgcw_pkg::*;
	`include "segment_grid_cell_walker_defines.svh"

	typedef enum logic [1:0] {W_IDLE, W_COL, W_STEP, W_TAIL} walk_state_t;

	walk_state_t state_q, state_n;
	cell_t       col_q, row_q, end_col_q, end_row_q;
	cell_t       col_n, row_n;
	logic        rising_q;
	diff_t       diff_q, diff_n, step_x_q, step_y_q;
	logic        out_valid_q, out_last_q;
	cell_t       out_x_q, out_y_q;

	logic  slot, want_emit, advance, emit_last, load, pos;
	cell_t emit_x, emit_y, col_inc;

	assign slot      = !out_valid_q || out_ready;
	assign advance   = !want_emit || slot;
	assign job_ready = state_q == W_IDLE;
	assign load      = state_q == W_IDLE && job_valid;
	assign pos       = diff_q > 0;
	assign col_inc   = col_q + 1'b1;

	assign out_valid  = out_valid_q;
	assign out_cell_x = out_x_q;
	assign out_cell_y = out_y_q;
	assign out_last   = out_last_q;

	always_comb begin
		state_n   = state_q;
		col_n     = col_q;
		row_n     = row_q;
		diff_n    = diff_q;
		want_emit = 1'b0;
		emit_x    = col_q;
		emit_y    = row_q;
		emit_last = 1'b0;
		unique case (state_q)
			W_IDLE: begin
				if (job_valid) begin
					state_n = (job.col < job.end_col) ? W_COL : W_TAIL;
				end
			end
			W_COL: begin
				want_emit = 1'b1;
				state_n   = W_STEP;
			end
			W_STEP: begin
				// Rising and falling both leave the column when the difference is not
				// positive for falling, or positive for rising.
				if (rising_q == pos) begin
					col_n  = col_inc;
					diff_n = diff_q - step_y_q;
					if (col_inc < end_col_q) begin
						want_emit = 1'b1;
						emit_x    = col_inc;
					end else begin
						state_n = W_TAIL;
					end
				end else if (rising_q) begin
					// An exact corner hit moves up a row without emitting the cell.
					row_n     = row_q + 1'b1;
					diff_n    = diff_q + step_x_q;
					want_emit = diff_q != 0;
					emit_y    = row_n;
				end else begin
					row_n     = row_q - 1'b1;
					diff_n    = diff_q - step_x_q;
					want_emit = 1'b1;
					emit_y    = row_n;
				end
			end
			W_TAIL: begin
				want_emit = 1'b1;
				if (row_q == end_row_q) begin
					emit_last = 1'b1;
					state_n   = W_IDLE;
				end else begin
					row_n = rising_q ? row_q + 1'b1 : row_q - 1'b1;
				end
			end
			default: begin
				state_n = W_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= W_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_n;
			end
			if (want_emit && slot) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q     <= job.col;
			row_q     <= job.row;
			end_col_q <= job.end_col;
			end_row_q <= job.end_row;
			rising_q  <= job.rising;
			diff_q    <= job.diff;
			step_x_q  <= job.step_x;
			step_y_q  <= job.step_y;
		end else if (advance) begin
			col_q  <= col_n;
			row_q  <= row_n;
			diff_q <= diff_n;
		end
		if (want_emit && slot) begin
			out_x_q    <= emit_x;
			out_y_q    <= emit_y;
			out_last_q <= emit_last;
		end
	end

	`SGCW_ASSERT_IMPLY(a_step_before_end_col, state_q == W_STEP, col_q < end_col_q,
		"walker is stepping inside a column at or past the final column")
	`SGCW_ASSERT_IMPLY(a_rise_row_bound, state_q == W_STEP && rising_q && diff_q <= 0,
		row_q < end_row_q, "rising segment would climb past its final row")
	`SGCW_ASSERT_IMPLY(a_fall_row_bound, state_q == W_STEP && !rising_q && diff_q > 0,
		row_q > end_row_q, "falling segment would drop past its final row")
	`SGCW_ASSERT_IMPLY(a_tail_direction, state_q == W_TAIL,
		rising_q ? row_q <= end_row_q : row_q >= end_row_q,
		"tail walk heads away from the final row")
	`SGCW_ASSERT_NEXT(a_last_emitted, state_q == W_TAIL && row_q == end_row_q && !out_valid_q,
		out_valid_q && out_last_q, "final cell of a segment was not presented")

endmodule

// File: rtl/segment_grid_cell_walker.sv
`timescale 1ns / 1ps

// Walks a line segment across a 32 by 32 grid and streams out every cell it touches, one
// beat per cell. The last beat, marked by tlast, carries the cell of the endpoint with the
// larger x, or of the finish point when both x are equal. Endpoints are unsigned 5.8 fixed
// point; they are put in order of rising x and each row step is decided by an exact
// product comparison, kept up by additions as the walk moves. The front end takes each
// segment through an accept, a multiply (both products at once) and a hand-over state, and
// can queue two segments ahead of the walker. The walker delivers one cell per cycle while
// the sink takes them, except that it emits nothing while loading each segment, on reaching
// the final column when the segment spans more than one column, and at every exact corner
// crossing of a rising segment. It takes no new segment until it has registered the last
// cell of the one before. A segment touches at most 63 cells.
module segment_grid_cell_walker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// start_x [12:0], start_y [25:13], finish_x [38:26], finish_y [51:39], zero fill above
	input  logic [sgcw_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// cell_x [4:0], cell_y [9:5], zero fill above
	output logic [sgcw_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	output logic                                 m_axis_tlast
);
	import sgcw_pkg::*;

	logic  front_valid, front_ready, walk_valid, walk_ready;
	job_t  front_job, walk_job;
	cell_t cell_x, cell_y;

	sgcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.start_x   (s_axis_tdata[FIELD_BITS-1:0]),
		.start_y   (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
		.finish_x  (s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
		.finish_y  (s_axis_tdata[4*FIELD_BITS-1:3*FIELD_BITS]),
		.job_valid (front_valid),
		.job_ready (front_ready),
		.job       (front_job)
	);

	sgcw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_job   (front_job),
		.pop_valid  (walk_valid),
		.pop_ready  (walk_ready),
		.pop_job    (walk_job)
	);

	sgcw_walker u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (walk_valid),
		.job_ready  (walk_ready),
		.job        (walk_job),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_cell_x (cell_x),
		.out_cell_y (cell_y),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_TDATA_BITS - 2 * CELL_BITS){1'b0}},
		CELL_BITS'(cell_y), CELL_BITS'(cell_x)};

endmodule

// File: verif/segment_grid_cell_walker_checker.sv
`timescale 1ns / 1ps

module segment_grid_cell_walker_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	input  logic                                 s_axis_tready,
	// start_x [12:0], start_y [25:13], finish_x [38:26], finish_y [51:39], zero fill above
	input  logic [sgcw_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	input  logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// cell_x [4:0], cell_y [9:5], zero fill above
	input  logic [sgcw_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
	input  logic                                 m_axis_tlast,
	output int                                   error_count,
	output int                                   cells_pending
);
	import sgcw_pkg::*;

	localparam int     MAX_CELLS = 63;
	localparam longint UNIT      = longint'(1) << FRAC_BITS;

	typedef struct packed {
		cell_t col;
		cell_t row;
		logic  last;
	} grid_cell_t;

	grid_cell_t expected_cells[$];
	grid_cell_t want_cell;
	int         segment_cells;

	task automatic add_cell(input longint col, input longint row, input logic last);
		grid_cell_t entry;
		if (segment_cells < MAX_CELLS) begin
			entry.col  = cell_t'(col);
			entry.row  = cell_t'(row);
			entry.last = last;
			expected_cells.push_back(entry);
			segment_cells++;
		end
	endtask

	task automatic walk_segment(input field_t sx, input field_t sy, input field_t fx,
			input field_t fy);
		longint ax, ay, bx, by, dx, dy, col, row, end_col, end_row, diff, held;
		ax = longint'(sx);
		ay = longint'(sy);
		bx = longint'(fx);
		by = longint'(fy);
		// Endpoints with equal x keep their order, so only a strictly smaller x swaps.
		if (bx < ax) begin
			held = ax; ax = bx; bx = held;
			held = ay; ay = by; by = held;
		end
		dx = bx - ax;
		dy = by - ay;
		end_col = bx >>> FRAC_BITS;
		end_row = by >>> FRAC_BITS;
		row = ay >>> FRAC_BITS;
		segment_cells = 0;
		if (ay <= by) begin
			for (col = ax >>> FRAC_BITS; col < end_col; col++) begin
				add_cell(col, row, 1'b0);
				forever begin
					diff = ((row + 1) * UNIT - ay) * dx - ((col + 1) * UNIT - ax) * dy;
					if (diff > 0)
						break;
					row++;
					// Through a corner the row moves on, but the cell above in the same column is skipped.
					if (diff != 0)
						add_cell(col, row, 1'b0);
				end
			end
			while (row < end_row) begin
				add_cell(end_col, row, 1'b0);
				row++;
			end
		end else begin
			for (col = ax >>> FRAC_BITS; col < end_col; col++) begin
				add_cell(col, row, 1'b0);
				forever begin
					// A falling segment through a corner stays in its row.
					diff = (row * UNIT - ay) * dx - ((col + 1) * UNIT - ax) * dy;
					if (diff <= 0)
						break;
					row--;
					add_cell(col, row, 1'b0);
				end
			end
			while (row > end_row) begin
				add_cell(end_col, row, 1'b0);
				row--;
			end
		end
		add_cell(end_col, end_row, 1'b1);
	endtask

	// A result beat can never belong to a segment accepted at the same edge, so the
	// comparison may run before the new segment is walked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_cells.size() == 0) begin
					$error("cell beat with nothing expected: cell_x=%0d cell_y=%0d last_cell=%0b",
						m_axis_tdata[CELL_BITS-1:0], m_axis_tdata[2*CELL_BITS-1:CELL_BITS],
						m_axis_tlast);
					error_count++;
				end else begin
					want_cell = expected_cells.pop_front();
					if (m_axis_tdata[CELL_BITS-1:0] !== want_cell.col) begin
						$error("cell_x: expected %0d, got %0d", want_cell.col,
							m_axis_tdata[CELL_BITS-1:0]);
						error_count++;
					end
					if (m_axis_tdata[2*CELL_BITS-1:CELL_BITS] !== want_cell.row) begin
						$error("cell_y: expected %0d, got %0d", want_cell.row,
							m_axis_tdata[2*CELL_BITS-1:CELL_BITS]);
						error_count++;
					end
					if (m_axis_tlast !== want_cell.last) begin
						$error("last_cell: expected %0b, got %0b", want_cell.last, m_axis_tlast);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				walk_segment(s_axis_tdata[FIELD_BITS-1:0],
					s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS],
					s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS],
					s_axis_tdata[4*FIELD_BITS-1:3*FIELD_BITS]);
			cells_pending = expected_cells.size();
		end
	end

endmodule

// File: verif/tb_segment_grid_cell_walker.sv
`timescale 1ns / 1ps

module tb_segment_grid_cell_walker;
	import sgcw_pkg::*;

	localparam int RANDOM_SEGMENTS  = 200;
	localparam int SINK_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES     = 100;
	localparam int UNIT             = 1 << FRAC_BITS;
	localparam int FIELD_MAX        = (1 << FIELD_BITS) - 1;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [IN_TDATA_BITS-1:0]   s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;
	logic                       m_axis_tlast;
	int                         error_count;
	int                         cells_pending;
	bit                         no_gaps;
	bit                         hold_request;

	segment_grid_cell_walker u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	segment_grid_cell_walker_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.error_count   (error_count),
		.cells_pending (cells_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("[segment_grid_cell_walker] ERROR");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic field_t fit_field(input int v);
		if (v < 0)
			return '0;
		if (v > FIELD_MAX)
			return field_t'(FIELD_MAX);
		return field_t'(v);
	endfunction

	// Sink side: random stalls, plus one long hold-off when the stimulus asks for it.
	initial begin
		int gap;
		bit hold_done;
		hold_done     = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_gaps ? 0 : pick_gap();
			if (hold_request && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(negedge clk);
		end
	end

	// Returns at the falling edge after the beat was taken, with tvalid still high.
	task automatic offer_segment(input field_t sx, input field_t sy, input field_t fx,
			input field_t fy);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_BITS - 4 * FIELD_BITS){1'b0}}, fy, fx, sy, sx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic make_segment(output field_t sx, output field_t sy, output field_t fx,
			output field_t fy);
		int kind, cx, cy, u, v, k1, k2;
		field_t held;
		kind = $urandom_range(0, 99);
		if (kind < 25) begin
			sx = field_t'($urandom);
			sy = field_t'($urandom);
			fx = field_t'($urandom);
			fy = field_t'($urandom);
		end else if (kind < 45) begin
			sx = field_t'($urandom);
			sy = field_t'($urandom);
			fx = fit_field(int'(sx) + int'($urandom_range(0, 1200)) - 600);
			fy = fit_field(int'(sy) + int'($urandom_range(0, 1200)) - 600);
		end else if (kind < 65) begin
			// Both endpoints on one line through a grid corner, unless clamped to the field range.
			cx = $urandom_range(1, 31) * UNIT;
			cy = $urandom_range(1, 31) * UNIT;
			u  = $urandom_range(1, 64);
			v  = int'($urandom_range(0, 128)) - 64;
			k1 = $urandom_range(1, 10);
			k2 = $urandom_range(1, 10);
			sx = fit_field(cx - k1 * u);
			sy = fit_field(cy - k1 * v);
			fx = fit_field(cx + k2 * u);
			fy = fit_field(cy + k2 * v);
		end else if (kind < 75) begin
			sx = field_t'($urandom);
			fx = sx;
			sy = field_t'($urandom);
			fy = field_t'($urandom);
		end else if (kind < 85) begin
			sx = field_t'($urandom);
			fx = field_t'($urandom);
			sy = field_t'($urandom);
			fy = sy;
		end else if (kind < 95) begin
			sx = fit_field($urandom_range(0, 31) * UNIT + ($urandom_range(0, 1) ? 0 : 255));
			sy = fit_field($urandom_range(0, 31) * UNIT + ($urandom_range(0, 1) ? 0 : 255));
			fx = fit_field($urandom_range(0, 31) * UNIT + $urandom_range(0, 2) * 128);
			fy = fit_field($urandom_range(0, 31) * UNIT + $urandom_range(0, 2) * 128);
		end else begin
			sx = $urandom_range(0, 1) ? field_t'(FIELD_MAX) : '0;
			sy = $urandom_range(0, 1) ? field_t'(FIELD_MAX) : '0;
			fx = $urandom_range(0, 1) ? field_t'(FIELD_MAX) : '0;
			fy = $urandom_range(0, 1) ? field_t'(FIELD_MAX) : '0;
		end
		if ($urandom_range(0, 1)) begin
			held = sx; sx = fx; fx = held;
			held = sy; sy = fy; fy = held;
		end
	endtask

	initial begin
		field_t sx, sy, fx, fy;
		int i;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		no_gaps       = 1'b0;
		hold_request  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		offer_segment(13'd0, 13'd0, 13'd0, 13'd0);
		offer_segment(13'd8191, 13'd8191, 13'd8191, 13'd8191);
		offer_segment(13'd0, 13'd0, 13'd8191, 13'd8191);
		offer_segment(13'd8191, 13'd0, 13'd0, 13'd8191);
		offer_segment(13'd0, 13'd8191, 13'd8191, 13'd0);
		offer_segment(13'd300, 13'd10, 13'd300, 13'd8000);
		offer_segment(13'd300, 13'd8000, 13'd300, 13'd10);
		offer_segment(13'd10, 13'd500, 13'd8100, 13'd500);
		offer_segment(13'd8191, 13'd0, 13'd0, 13'd0);
		offer_segment(13'd0, 13'd0, 13'd512, 13'd512);
		offer_segment(13'd0, 13'd512, 13'd512, 13'd0);
		offer_segment(13'd0, 13'd0, 13'd1024, 13'd512);
		offer_segment(13'd1024, 13'd0, 13'd0, 13'd512);
		offer_segment(13'd100, 13'd100, 13'd200, 13'd200);
		offer_segment(13'd200, 13'd100, 13'd300, 13'd100);
		offer_segment(13'd100, 13'd0, 13'd150, 13'd8191);
		offer_segment(13'd8000, 13'd8191, 13'd8100, 13'd0);
		offer_segment(13'h1555, 13'h0AAA, 13'h0AAA, 13'h1555);
		offer_segment(13'h0AAA, 13'h1555, 13'h1555, 13'h0AAA);
		offer_segment(13'd256, 13'd256, 13'd256, 13'd256);
		offer_segment(13'd255, 13'd255, 13'd256, 13'd256);

		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (cells_pending != 0);

		for (i = 0; i < RANDOM_SEGMENTS; i++) begin
			no_gaps = ((i / 25) % 4 == 3);
			if (i == 40)
				hold_request = 1'b1;
			// Let every cell drain before carrying on.
			if (i == 130) begin
				s_axis_tvalid <= 1'b0;
				do
					@(negedge clk);
				while (cells_pending != 0);
			end
			make_segment(sx, sy, fx, fy);
			offer_segment(sx, sy, fx, fy);
		end

		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (cells_pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("[segment_grid_cell_walker] OK");
		else
			$display("[segment_grid_cell_walker] ERROR");
		$finish;
	end

endmodule
